@@ hdl/prue_pkg.sv @@
// Package for the particle ring update engine.
// Holds the item types, slot constants and opcodes shared by all modules but prue_ram.
// No dependencies.
package prue_pkg;

  localparam int NumParticles = 64;
  localparam int SlotW        = $clog2(NumParticles);
  localparam int FactOne      = 65536;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        now_ms;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        begin_color;
    logic [31:0]        final_color;
    logic [31:0]        life_ms;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         slot_index;
    logic               alive;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        blend_color;
    logic [5:0]         next_slot;
    logic               last;
  } out_item_t;

  typedef struct packed {
    op_e      op;
    in_item_t item;
  } cmd_t;

  // One stored particle, everything but its current color.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] birth;
    logic [31:0] life;
    logic [31:0] scol;
    logic [31:0] ecol;
  } prec_t;

  localparam int PrecW = $bits(prec_t);

endpackage

@@ hdl/prue_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prue_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/prue_front.sv @@
// Front end: accepts input items, decodes the request type and queues commands.
// Depends on prue_pkg.
module prue_front import prue_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  cmd_t       fifo_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rptr_q];

  always_comb begin
    cmd_in.item = in_item_i;
    cmd_in.op   = in_item_i.req_type ? OP_TICK : OP_INSERT;
    wptr_d      = push ? ~wptr_q : wptr_q;
    rptr_d      = pop ? ~rptr_q : rptr_q;
    cnt_d       = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ hdl/prue_fact.sv @@
// Blend factor unit: floor(sqrt(elapsed * 2^32 / life)) for elapsed < life.
// A restoring divider (one bit a cycle) followed by a digit-by-digit root.
// Depends on prue_pkg.
module prue_fact import prue_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] elapsed_i,
  input  logic [31:0] life_i,
  output logic        done_o,
  output logic [15:0] fact_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_SQRT = 2'd2;
  localparam logic [1:0] F_DONE = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] div_q, div_d;
  logic [19:0] srem_q, srem_d;
  logic [15:0] root_q, root_d;
  logic [32:0] shl;
  logic [19:0] srem_sh, trial;

  assign shl     = {rem_q[31:0], 1'b0};
  assign srem_sh = {srem_q[17:0], quo_q[31:30]};
  assign trial   = {2'b00, root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    srem_d  = srem_q;
    root_d  = root_q;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          rem_d   = {1'b0, elapsed_i};
          div_d   = life_i;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        // The remainder stays below the divisor, so the quotient fits 32 bits.
        if (shl >= {1'b0, div_q}) begin
          rem_d = shl - {1'b0, div_q};
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = shl;
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = F_SQRT;
        end
      end
      F_SQRT: begin
        quo_d = {quo_q[29:0], 2'b00};
        if (srem_sh >= trial) begin
          srem_d = srem_sh - trial;
          root_d = {root_q[14:0], 1'b1};
        end else begin
          srem_d = srem_sh;
          root_d = {root_q[14:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          state_d = F_DONE;
        end
      end
      F_DONE: state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign done_o = (state_q == F_DONE);
  assign fact_o = root_q;

endmodule

@@ hdl/prue_back.sv @@
// Back end: executes inserts and ticks against the slot memories, one slot at a time.
// Depends on prue_pkg, prue_ram and prue_fact.
module prue_back import prue_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_INSR  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_FACT  = 3'd5;
  localparam logic [2:0] S_BLEND = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]              state_q, state_d;
  logic [SlotW-1:0]        slot_q, slot_d, wp_q, wp_d, wp_nxt;
  logic [NumParticles-1:0] bvld_q, bvld_d, cvld_q, cvld_d;
  logic [31:0]             grav_q;
  logic [16:0]             f_q, f_d;
  in_item_t                item_q;
  out_item_t               res_q, res_d, out_q;
  logic                    out_vld_q, out_vld_d, is_ins_q, is_ins_d;

  logic             p_we, c_we, p_re, c_re, f_start, f_done, slot_last;
  logic [SlotW-1:0] p_waddr, c_raddr;
  prec_t            p_wdata, p_rdata;
  logic [31:0]      c_wdata, c_rdata, col_cur, elapsed, vy_new, col_mix;
  logic [15:0]      f_root;
  logic [16:0]      f_inv;
  logic [25:0]      chan;

  prue_ram #(.Width(PrecW), .Depth(NumParticles)) u_prec_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(slot_q), .rdata_o(p_rdata)
  );

  prue_ram #(.Width(32), .Depth(NumParticles)) u_col_ram (
    .clk_i, .we_i(c_we), .waddr_i(slot_q), .wdata_i(c_wdata),
    .re_i(c_re), .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  prue_fact u_fact (
    .clk_i, .rst_ni, .start_i(f_start), .elapsed_i(elapsed),
    .life_i(p_rdata.life), .done_o(f_done), .fact_o(f_root)
  );

  assign wp_nxt    = (wp_q == SlotW'(NumParticles - 1)) ? '0 : wp_q + 1'b1;
  assign slot_last = (slot_q == SlotW'(NumParticles - 1));
  assign c_raddr   = (state_q == S_INS) ? wp_q : slot_q;
  assign elapsed   = item_q.now_ms - p_rdata.birth;
  assign vy_new    = p_rdata.vy + grav_q;
  assign f_inv     = 17'(FactOne) - f_q;

  // Color read back for the slot in hand; a never-written entry reads as zero.
  always_comb begin
    col_cur = cvld_q[c_raddr] ? c_rdata : '0;
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      chan = 26'(p_rdata.scol[8*c +: 8]) * 26'(f_inv)
           + 26'(p_rdata.ecol[8*c +: 8]) * 26'(f_q);
      col_mix[8*c +: 8] = chan[23:16];
    end
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    wp_d        = wp_q;
    bvld_d      = bvld_q;
    cvld_d      = cvld_q;
    f_d         = f_q;
    res_d       = res_q;
    is_ins_d    = is_ins_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    cmd_ready_o = 1'b0;
    p_we        = 1'b0;
    c_we        = 1'b0;
    p_re        = 1'b0;
    c_re        = 1'b0;
    f_start     = 1'b0;
    p_waddr     = slot_q;
    p_wdata     = p_rdata;
    c_wdata     = col_cur;
    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          is_ins_d = (cmd_i.op == OP_INSERT);
          slot_d   = '0;
          state_d  = (cmd_i.op == OP_INSERT) ? S_INS : S_RD;
        end
      end
      S_INS: begin
        p_we          = 1'b1;
        p_waddr       = wp_q;
        p_wdata.x     = item_q.pos_x;
        p_wdata.y     = item_q.pos_y;
        p_wdata.z     = item_q.pos_z;
        p_wdata.vx    = item_q.vel_x;
        p_wdata.vy    = item_q.vel_y;
        p_wdata.vz    = item_q.vel_z;
        p_wdata.birth = item_q.now_ms;
        p_wdata.life  = item_q.life_ms;
        p_wdata.scol  = item_q.begin_color;
        p_wdata.ecol  = item_q.final_color;
        bvld_d[wp_q]  = 1'b1;
        c_re          = 1'b1;
        slot_d        = wp_q;
        state_d       = S_INSR;
      end
      S_INSR: begin
        // An insert at time zero leaves the slot marked free.
        res_d.slot_index  = 6'(wp_q);
        res_d.alive       = (item_q.now_ms != '0);
        res_d.out_x       = res_d.alive ? item_q.pos_x : '0;
        res_d.out_y       = res_d.alive ? item_q.pos_y : '0;
        res_d.out_z       = res_d.alive ? item_q.pos_z : '0;
        res_d.blend_color = col_cur;
        res_d.next_slot   = 6'(wp_nxt);
        res_d.last        = 1'b1;
        wp_d              = wp_nxt;
        state_d           = S_EMIT;
      end
      S_RD: begin
        p_re    = 1'b1;
        c_re    = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        res_d.slot_index  = 6'(slot_q);
        res_d.alive       = 1'b0;
        res_d.out_x       = '0;
        res_d.out_y       = '0;
        res_d.out_z       = '0;
        res_d.blend_color = col_cur;
        res_d.next_slot   = 6'(wp_q);
        res_d.last        = slot_last;
        if (!bvld_q[slot_q] || p_rdata.birth == '0) begin
          state_d = S_EMIT;
        end else if (elapsed > p_rdata.life) begin
          p_we              = 1'b1;
          p_wdata.birth     = '0;
          c_we              = 1'b1;
          c_wdata           = {8'h00, col_cur[23:0]};
          cvld_d[slot_q]    = 1'b1;
          res_d.blend_color = {8'h00, col_cur[23:0]};
          state_d           = S_EMIT;
        end else if (elapsed == p_rdata.life) begin
          f_d     = 17'(FactOne);
          state_d = S_BLEND;
        end else begin
          f_start = 1'b1;
          state_d = S_FACT;
        end
      end
      S_FACT: begin
        if (f_done) begin
          f_d     = {1'b0, f_root};
          state_d = S_BLEND;
        end
      end
      S_BLEND: begin
        p_we              = 1'b1;
        p_wdata.vy        = vy_new;
        p_wdata.x         = p_rdata.x + p_rdata.vx;
        p_wdata.y         = p_rdata.y + vy_new;
        p_wdata.z         = p_rdata.z + p_rdata.vz;
        c_we              = 1'b1;
        c_wdata           = col_mix;
        cvld_d[slot_q]    = 1'b1;
        res_d.alive       = 1'b1;
        res_d.out_x       = p_wdata.x;
        res_d.out_y       = p_wdata.y;
        res_d.out_z       = p_wdata.z;
        res_d.blend_color = col_mix;
        state_d           = S_EMIT;
      end
      S_EMIT: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          if (is_ins_q || slot_last) begin
            state_d = S_IDLE;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    res_q <= res_d;
    if (state_q == S_IDLE && cmd_valid_i) begin
      item_q <= cmd_i.item;
    end
    if (state_q == S_EMIT && (!out_vld_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      slot_q    <= '0;
      wp_q      <= '0;
      bvld_q    <= '0;
      cvld_q    <= '0;
      is_ins_q  <= 1'b0;
      out_vld_q <= 1'b0;
      grav_q    <= '0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      wp_q      <= wp_d;
      bvld_q    <= bvld_d;
      cvld_q    <= cvld_d;
      is_ins_q  <= is_ins_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        grav_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

@@ hdl/particle_ring_update_engine_top.sv @@
// Top level of the particle ring update engine.
// Depends on prue_pkg, prue_front and prue_back.
//
// Usage: input items arrive on the in channel (valid/ready), results leave on
// the out channel (valid/ready), and the gravity register is written on the
// cfg channel, which is always ready and is meant to be written while idle.
// An insert transaction passes through the insert, insert-result and emit
// states before its result enters the output register. A tick gives one
// result per slot, in slot order, with last set on the final one. A free or
// expiring slot is read, evaluated and emitted; a slot whose age equals its
// life is also blended, and any other live slot first waits on the factor
// unit: a bit-serial restoring divider, a square root and a done state that
// hands the factor over. The back end returns to idle between transactions.
// A two-entry command queue lets the next items be taken while the back end
// works or the output register waits. When the receiver stalls, the result
// holds in the output register and the back end waits.
// Reset frees all slots, zeroes all current colors, the write pointer and
// gravity; no clearing pass is needed, the engine is ready right away.
module particle_ring_update_engine_top import prue_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  prue_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  prue_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_data_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

endmodule

@@ hdl/prue_checker.sv @@
// Port-level checker for the particle ring update engine, bound to the top.
// Depends on prue_pkg.
module prue_checker import prue_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input in_item_t    in_item_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_item_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("waiting input transaction changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.alive |->
      out_item_o.out_x == '0 && out_item_o.out_y == '0 && out_item_o.out_z == '0)
    else $error("free slot reports a position");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.slot_index != 6'(NumParticles - 1))
    else $error("last slot of a tick without last flag");

endmodule

bind particle_ring_update_engine_top prue_checker u_prue_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for particle_ring_update_engine_top.
// Depends on prue_pkg and the engine RTL; it predicts in-line or hand-writes every
// expected result and checks it against the out channel.
module testbench;
  import prue_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  // Shadow copy of the particle store.
  logic [31:0] px_m[NumParticles], py_m[NumParticles], pz_m[NumParticles];
  logic [31:0] vx_m[NumParticles], vy_m[NumParticles], vz_m[NumParticles];
  logic [31:0] born_m[NumParticles], life_m[NumParticles];
  logic [31:0] scol_m[NumParticles], ecol_m[NumParticles], ccol_m[NumParticles];
  logic [5:0]  wptr_m;
  logic [31:0] gravity_m;

  out_item_t pending_results[$];
  int errors = 0;
  int n_inserts = 0, n_ticks = 0, n_results = 0, n_cfg = 0;
  bit no_gaps = 0;
  bit hold_armed = 0;

  particle_ring_update_engine_top uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(60ms);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] fade_factor(logic [31:0] age, logic [31:0] life);
    logic [31:0] f;
    if (life == 0 || age >= life) return FactOne;
    f = int_sqrt({age, 32'd0} / {32'd0, life});
    return (f > FactOne) ? FactOne : f;
  endfunction

  function automatic logic [31:0] mix_rgba(logic [31:0] s, logic [31:0] d, logic [31:0] f);
    logic [31:0] o;
    logic [63:0] c;
    o = 0;
    for (int sh = 0; sh < 32; sh += 8) begin
      c = ((64'(s[sh+:8]) * (64'(FactOne) - f)) + (64'(d[sh+:8]) * f)) >> 16;
      o[sh+:8] = c[7:0];
    end
    return o;
  endfunction

  // Updates the shadow store for one accepted transaction and queues its results.
  // A row with a hand-written expectation queues that one instead.
  task automatic advance_particles(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t r;
    logic [5:0] p;
    logic [31:0] age;
    if (it.req_type == OP_INSERT) begin
      p = wptr_m;
      px_m[p] = it.pos_x; py_m[p] = it.pos_y; pz_m[p] = it.pos_z;
      vx_m[p] = it.vel_x; vy_m[p] = it.vel_y; vz_m[p] = it.vel_z;
      scol_m[p] = it.begin_color; ecol_m[p] = it.final_color;
      life_m[p] = it.life_ms; born_m[p] = it.now_ms;
      wptr_m = p + 6'd1;
      r = '0;
      r.slot_index = p;
      r.alive = (it.now_ms != 0);
      if (r.alive) begin
        r.out_x = px_m[p]; r.out_y = py_m[p]; r.out_z = pz_m[p];
      end
      r.blend_color = ccol_m[p];
      r.next_slot = wptr_m;
      r.last = 1'b1;
      pending_results.push_back(typed ? typed_res : r);
      n_inserts++;
    end else begin
      for (int s = 0; s < NumParticles; s++) begin
        r = '0;
        r.slot_index = 6'(s);
        if (born_m[s] != 0) begin
          age = it.now_ms - born_m[s];
          if (age > life_m[s]) begin
            born_m[s] = 0;
            ccol_m[s][31:24] = 8'h00;
          end else begin
            ccol_m[s] = mix_rgba(scol_m[s], ecol_m[s], fade_factor(age, life_m[s]));
            vy_m[s] += gravity_m;
            px_m[s] += vx_m[s]; py_m[s] += vy_m[s]; pz_m[s] += vz_m[s];
            r.alive = 1'b1;
            r.out_x = px_m[s]; r.out_y = py_m[s]; r.out_z = pz_m[s];
          end
        end
        r.blend_color = ccol_m[s];
        r.next_slot = wptr_m;
        r.last = (s == NumParticles - 1);
        pending_results.push_back(r);
      end
      n_ticks++;
    end
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    advance_particles(it, typed, typed_res);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // Leave margin after the last expected result.
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_gravity(logic [31:0] g);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= g;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    gravity_m = g;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t mk_item(op_e op, logic [31:0] now, logic [31:0] x,
                                       logic [31:0] y, logic [31:0] z, logic [31:0] vx,
                                       logic [31:0] vy, logic [31:0] vz, logic [31:0] bc,
                                       logic [31:0] fc, logic [31:0] life);
    in_item_t it;
    it.req_type = op; it.now_ms = now;
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
    it.begin_color = bc; it.final_color = fc; it.life_ms = life;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic [5:0] slot, logic alive, logic [31:0] x,
                                       logic [31:0] y, logic [31:0] z, logic [31:0] col,
                                       logic [5:0] nxt);
    out_item_t r;
    r.slot_index = slot; r.alive = alive; r.out_x = x; r.out_y = y; r.out_z = z;
    r.blend_color = col; r.next_slot = nxt; r.last = 1'b1;
    return r;
  endfunction

  task automatic report(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_item_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        report("slot_index", e.slot_index, out_item_o.slot_index);
        report("alive", e.alive, out_item_o.alive);
        report("out_x", e.out_x, out_item_o.out_x);
        report("out_y", e.out_y, out_item_o.out_y);
        report("out_z", e.out_z, out_item_o.out_z);
        report("blend_color", e.blend_color, out_item_o.blend_color);
        report("next_slot", e.next_slot, out_item_o.next_slot);
        report("last", e.last, out_item_o.last);
      end
    end
  end

  // Result receiver with random stalls and one long hold-off.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_armed) begin
        hold_armed = 0;
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    in_item_t it;
    logic [31:0] clock_ms;
    out_item_t none;

    none = '0;
    for (int s = 0; s < NumParticles; s++) begin
      px_m[s] = 0; py_m[s] = 0; pz_m[s] = 0; vx_m[s] = 0; vy_m[s] = 0; vz_m[s] = 0;
      born_m[s] = 0; life_m[s] = 0; scol_m[s] = 0; ecol_m[s] = 0; ccol_m[s] = 0;
    end
    wptr_m = 0;
    gravity_m = 0;

    // Fresh slots report a current color of zero on insert.
    rows.push_back('{mk_item(OP_INSERT, 100, 32'h7FFFFFFF, 32'h80000000, 0, 1, 32'hFFFFFFFF,
                   32'h10000, 32'hFF000000, 32'h00FFFFFF, 1000), 1,
                   mk_res(0, 1, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1)});
    // Insert at time zero leaves the slot free.
    rows.push_back('{mk_item(OP_INSERT, 0, 5, 6, 7, 8, 9, 10, 32'h12345678, 32'h9ABCDEF0, 10),
                   1, mk_res(1, 0, 0, 0, 0, 0, 2)});
    // Zero life.
    rows.push_back('{mk_item(OP_INSERT, 100, 32'h00010000, 0, 32'hFFFF0000, 32'h7FFFFFFF,
                   32'h80000000, 32'h80000000, 32'hFFFFFFFF, 0, 0), 1,
                   mk_res(2, 1, 32'h00010000, 0, 32'hFFFF0000, 0, 3)});
    // Age will equal life at the first tick.
    rows.push_back('{mk_item(OP_INSERT, 50, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                   32'h80000000, 0, 32'h7FFFFFFF, 0, 32'hFFFFFFFF, 50), 1,
                   mk_res(3, 1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 4)});
    rows.push_back('{mk_item(OP_INSERT, 200, 1, 2, 3, 4, 5, 6, 32'hA5A5A5A5, 32'h5A5A5A5A,
                   32'hFFFFFFFF), 1, mk_res(4, 1, 1, 2, 3, 0, 5)});
    rows.push_back('{mk_item(OP_TICK, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_item(OP_TICK, 101, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_item(OP_TICK, 600, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    // Old particles expire and lose their alpha.
    rows.push_back('{mk_item(OP_TICK, 2000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    // Birth just before the time counter wraps.
    rows.push_back('{mk_item(OP_INSERT, 32'hFFFFFFF0, 32'hDEADBEEF, 32'h0BADF00D, 32'hCAFE0000,
                   32'h00000100, 32'hFFFFFF00, 0, 32'h00FF00FF, 32'hFF00FF00, 100), 1,
                   mk_res(5, 1, 32'hDEADBEEF, 32'h0BADF00D, 32'hCAFE0000, 0, 6)});
    rows.push_back('{mk_item(OP_TICK, 32'h10, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_item(OP_TICK, 32'h80, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_item(OP_TICK, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_gravity(32'h7FFFFFFF);
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.item, row.typed, row.res);
    end
    drain_results();

    clock_ms = $urandom_range(1000, 100000);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: write_gravity(32'h80000000);
        1: write_gravity($urandom);
        default: write_gravity(32'h00000000);
      endcase
      for (int n = 0; n < 40; n++) begin
        if (n % 13 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (phase == 1 && n == 10) hold_armed = 1;
        clock_ms += $urandom_range(1, 400);
        if ($urandom_range(0, 30) == 0) clock_ms = $urandom;
        it.req_type = ($urandom_range(0, 9) < 7) ? OP_INSERT : OP_TICK;
        it.now_ms = ($urandom_range(0, 19) == 0) ? 32'd0 : clock_ms;
        it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
        it.vel_x = $urandom; it.vel_y = $urandom; it.vel_z = $urandom;
        it.begin_color = $urandom; it.final_color = $urandom;
        case ($urandom_range(0, 9))
          0: it.life_ms = 0;
          1: it.life_ms = $urandom;
          default: it.life_ms = $urandom_range(1, 3000);
        endcase
        send_item(it, 0, none);
      end
      no_gaps = 0;
      drain_results();
    end

    $display("Covered %0d inserts and %0d ticks, %0d results checked, %0d gravity writes.",
             n_inserts, n_ticks, n_results, n_cfg);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
